// File: rtl/humidity_sensor_frame_decoder_unit_assert.svh
// Assertion macros for the checker file of the decoder.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_UNIT_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_UNIT_ASSERT_SVH

// Implication in the same cycle.
`define HSFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle.
`define HSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hsfd_pkg.sv
package hsfd_pkg;

    localparam logic [7:0]  CRC8_GEN   = 8'h31;
    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    localparam logic [15:0] TICKS_FULL = 16'hFFFF;
    localparam logic [7:0]  T_SCALE    = 8'd175;
    localparam logic [8:0]  T_OFFSET   = 9'd45;
    localparam logic [7:0]  H_SCALE    = 8'd125;
    localparam logic [7:0]  H_OFFSET   = 8'd6;
    localparam logic [6:0]  H_MAX      = 7'd100;

    typedef struct packed {
        logic        vld;
        logic [15:0] t_raw;
        logic [15:0] h_raw;
        logic        t_ok;
        logic        h_ok;
    } t_frame;

    typedef struct packed {
        logic signed [8:0] temperature_c;
        logic [6:0]        humidity_pct;
        logic              temperature_ok;
        logic              humidity_ok;
    } t_result;

endpackage

// File: rtl/hsfd_rx_if.sv
interface hsfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// File: rtl/hsfd_res_if.sv
interface hsfd_res_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] temperature_c;
    logic [6:0]        humidity_pct;
    logic              temperature_ok;
    logic              humidity_ok;

    modport source (
        output valid, output temperature_c, output humidity_pct,
        output temperature_ok, output humidity_ok, input ready
    );
    modport sink (
        input valid, input temperature_c, input humidity_pct,
        input temperature_ok, input humidity_ok, output ready
    );
endinterface

// File: rtl/humidity_sensor_frame_decoder_unit.sv
// Decoder for the six-byte measurement reply of a temperature and humidity sensor.
// Channel i_rx carries one received byte per transaction, with frame_start set on
// the first byte of a reply; a start flag in mid-frame drops the partial frame.
// Bytes 0..1 are the temperature word and byte 2 its CRC-8, bytes 3..4 the humidity
// word and byte 5 its CRC-8 (polynomial 0x31, initial value 0xFF, MSB first).
// Channel o_res carries one result transaction per frame: temperature in degrees
// Celsius, humidity in percent clamped to 0..100, and a CRC flag for each word;
// a word that fails its CRC is given as zero.
// Throughput is one byte per clock cycle while bytes are not held back. Once the sixth
// byte is accepted, the frame passes through the frame register and the scaling
// product register into the result register.
// Reset returns the byte position to the start of a frame, loads the CRC with 0xFF
// and empties the pipeline. While o_res is stalled the result is held and bytes
// are still taken; the frame and product registers can each hold one more frame,
// and only the sixth byte of a frame waits when both are full.
module humidity_sensor_frame_decoder_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hsfd_rx_if.sink           i_rx,
    hsfd_res_if.source        o_res
);

    hsfd_pkg::t_frame  frm;
    hsfd_pkg::t_result res;
    logic              frm_en;
    logic              res_vld;

    hsfd_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (i_rx.valid),
        .i_byte   (i_rx.rx_byte),
        .i_start  (i_rx.frame_start),
        .o_rdy    (i_rx.ready),
        .i_frm_en (frm_en),
        .o_frm    (frm)
    );

    hsfd_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frm     (frm),
        .o_frm_en  (frm_en),
        .o_res_vld (res_vld),
        .i_res_rdy (o_res.ready),
        .o_res     (res)
    );

    assign o_res.valid          = res_vld;
    assign o_res.temperature_c  = res.temperature_c;
    assign o_res.humidity_pct   = res.humidity_pct;
    assign o_res.temperature_ok = res.temperature_ok;
    assign o_res.humidity_ok    = res.humidity_ok;

endmodule

// File: rtl/hsfd_frame.sv
module hsfd_frame (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [7:0]       i_byte,
    input  logic             i_start,
    output logic             o_rdy,
    input  logic             i_frm_en,
    output hsfd_pkg::t_frame o_frm
);

    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ hsfd_pkg::CRC8_GEN) : (c << 1);
        end
        return c;
    endfunction

    logic [2:0]       r_pos, n_pos;
    logic [7:0]       r_crc, n_crc;
    logic [15:0]      r_t_raw, n_t_raw;
    logic [15:0]      r_h_raw, n_h_raw;
    logic             r_t_good, n_t_good;
    hsfd_pkg::t_frame r_frm, n_frm;

    logic       frm_en;
    logic       acc;
    logic       restart;
    logic [2:0] pos;
    logic [7:0] crc;

    assign frm_en  = !r_frm.vld || i_frm_en;
    assign o_rdy   = frm_en || (r_pos != POS_H_CRC);
    assign acc     = i_vld && o_rdy;
    assign restart = i_start || (r_pos > POS_H_CRC);
    assign pos     = restart ? POS_T_MSB : r_pos;
    assign crc     = restart ? hsfd_pkg::CRC_INIT : r_crc;
    assign o_frm   = r_frm;

    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_t_raw  = r_t_raw;
        n_h_raw  = r_h_raw;
        n_t_good = r_t_good;
        n_frm    = r_frm;
        if (frm_en) begin
            n_frm.vld = 1'b0;
        end
        if (acc) begin
            n_pos = pos + 3'd1;
            n_crc = crc8_step(crc, i_byte);
            unique case (pos)
                POS_T_MSB: begin
                    n_t_raw[15:8] = i_byte;
                end
                POS_T_LSB: begin
                    n_t_raw[7:0] = i_byte;
                end
                POS_T_CRC: begin
                    n_t_good = (crc == i_byte);
                    n_crc    = hsfd_pkg::CRC_INIT;
                end
                POS_H_MSB: begin
                    n_h_raw[15:8] = i_byte;
                end
                POS_H_LSB: begin
                    n_h_raw[7:0] = i_byte;
                end
                default: begin
                    n_pos       = POS_T_MSB;
                    n_crc       = hsfd_pkg::CRC_INIT;
                    n_frm.vld   = 1'b1;
                    n_frm.t_raw = r_t_raw;
                    n_frm.h_raw = r_h_raw;
                    n_frm.t_ok  = r_t_good;
                    n_frm.h_ok  = (crc == i_byte);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_T_MSB;
            r_crc     <= hsfd_pkg::CRC_INIT;
            r_frm.vld <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_frm.vld <= n_frm.vld;
        end
        r_t_raw    <= n_t_raw;
        r_h_raw    <= n_h_raw;
        r_t_good   <= n_t_good;
        r_frm.t_raw <= n_frm.t_raw;
        r_frm.h_raw <= n_frm.h_raw;
        r_frm.t_ok  <= n_frm.t_ok;
        r_frm.h_ok  <= n_frm.h_ok;
    end

endmodule

// File: rtl/hsfd_scale.sv
module hsfd_scale (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsfd_pkg::t_frame  i_frm,
    output logic              o_frm_en,
    output logic              o_res_vld,
    input  logic              i_res_rdy,
    output hsfd_pkg::t_result o_res
);

    // Quotient of a product below 256 * 65535 by 65535, using 2^16 = 65535 + 1.
    function automatic logic [7:0] div_full(input logic [23:0] p);
        logic [7:0]  q0;
        logic [16:0] r;
        q0 = p[23:16];
        r  = {1'b0, p[15:0]} + {9'd0, q0};
        return q0 + {7'd0, (r >= {1'b0, hsfd_pkg::TICKS_FULL})};
    endfunction

    logic              r_prd_vld, n_prd_vld;
    logic [23:0]       r_t_prod, n_t_prod;
    logic [23:0]       r_h_prod, n_h_prod;
    logic              r_t_ok, n_t_ok;
    logic              r_h_ok, n_h_ok;
    logic              r_res_vld, n_res_vld;
    hsfd_pkg::t_result r_res, n_res;

    logic       out_en;
    logic       prd_en;
    logic [7:0] t_q;
    logic [7:0] h_q;
    logic [6:0] h_val;

    assign out_en    = !r_res_vld || i_res_rdy;
    assign prd_en    = !r_prd_vld || out_en;
    assign o_frm_en  = prd_en;
    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    assign t_q = div_full(r_t_prod);
    assign h_q = div_full(r_h_prod);

    always_comb begin
        if (h_q < hsfd_pkg::H_OFFSET) begin
            h_val = 7'd0;
        end else if (h_q > ({1'b0, hsfd_pkg::H_MAX} + hsfd_pkg::H_OFFSET)) begin
            h_val = hsfd_pkg::H_MAX;
        end else begin
            h_val = 7'(h_q - hsfd_pkg::H_OFFSET);
        end
    end

    always_comb begin
        n_prd_vld = r_prd_vld;
        n_t_prod  = r_t_prod;
        n_h_prod  = r_h_prod;
        n_t_ok    = r_t_ok;
        n_h_ok    = r_h_ok;
        if (prd_en) begin
            n_prd_vld = i_frm.vld;
            if (i_frm.vld) begin
                n_t_prod = 24'(i_frm.t_raw) * 24'(hsfd_pkg::T_SCALE);
                n_h_prod = 24'(i_frm.h_raw) * 24'(hsfd_pkg::H_SCALE);
                n_t_ok   = i_frm.t_ok;
                n_h_ok   = i_frm.h_ok;
            end
        end
    end

    always_comb begin
        n_res_vld = r_res_vld;
        n_res     = r_res;
        if (out_en) begin
            n_res_vld = r_prd_vld;
            if (r_prd_vld) begin
                n_res.temperature_ok = r_t_ok;
                n_res.humidity_ok    = r_h_ok;
                n_res.temperature_c  = r_t_ok ?
                    $signed({1'b0, t_q} - hsfd_pkg::T_OFFSET) : 9'sd0;
                n_res.humidity_pct   = r_h_ok ? h_val : 7'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prd_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_prd_vld <= n_prd_vld;
            r_res_vld <= n_res_vld;
        end
        r_t_prod <= n_t_prod;
        r_h_prod <= n_h_prod;
        r_t_ok   <= n_t_ok;
        r_h_ok   <= n_h_ok;
        r_res    <= n_res;
    end

endmodule

// File: rtl/hsfd_checker.sv
`include "humidity_sensor_frame_decoder_unit_assert.svh"

module hsfd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_rx_ready,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic signed [8:0] i_res_temperature_c,
    input logic [6:0]        i_res_humidity_pct,
    input logic              i_res_temperature_ok,
    input logic              i_res_humidity_ok
);

    `HSFD_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_res_temperature_c) && $stable(i_res_humidity_pct)
        && $stable(i_res_temperature_ok) && $stable(i_res_humidity_ok),
        "result changed while stalled")
    `HSFD_ASSERT_SAME(a_idle_ready, !i_res_valid, i_rx_ready,
        "input stalled with an empty result register")
    `HSFD_ASSERT_SAME(a_bad_crc_zero, i_res_valid,
        (i_res_temperature_ok || (i_res_temperature_c == 9'sd0))
        && (i_res_humidity_ok || (i_res_humidity_pct == 7'd0)),
        "failed word not given as zero")
    `HSFD_ASSERT_SAME(a_range, i_res_valid,
        (i_res_humidity_pct <= 7'd100) && (i_res_temperature_c >= -9'sd45)
        && (i_res_temperature_c <= 9'sd130),
        "result out of range")

endmodule

bind humidity_sensor_frame_decoder_unit hsfd_checker u_hsfd_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_rx_ready           (i_rx.ready),
    .i_res_valid          (o_res.valid),
    .i_res_ready          (o_res.ready),
    .i_res_temperature_c  (o_res.temperature_c),
    .i_res_humidity_pct   (o_res.humidity_pct),
    .i_res_temperature_ok (o_res.temperature_ok),
    .i_res_humidity_ok    (o_res.humidity_ok)
);

// File: dv/humidity_sensor_frame_decoder_unit_test.sv
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder_unit_test;

    typedef struct {
        logic [7:0] data;
        logic       start;
        bit         wait_drain;
    } t_rx_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hsfd_rx_if  rx_if ();
    hsfd_res_if res_if ();

    humidity_sensor_frame_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always #1 i_clk = ~i_clk;

    t_rx_beat          pending_beats[$];
    hsfd_pkg::t_result expected_readings[$];

    logic [2:0]  frame_pos;
    logic [7:0]  word_crc;
    logic [15:0] t_ticks;
    logic [15:0] h_ticks;
    logic        t_crc_good;

    int mismatch_count = 0;
    int beats_sent = 0;
    int readings_seen = 0;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ hsfd_pkg::CRC8_GEN) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] word_crc8(input logic [15:0] w);
        return crc8_step(crc8_step(hsfd_pkg::CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // Tracks the decoder state for one accepted byte and queues the reading
    // that completes on the sixth byte of a frame.
    task automatic decode_byte(input logic [7:0] b, input logic start);
        hsfd_pkg::t_result r;
        int      t;
        int      h;
        logic    h_good;
        if (start || frame_pos > 3'd5) begin
            frame_pos = 3'd0;
            word_crc  = hsfd_pkg::CRC_INIT;
        end
        case (frame_pos)
            3'd0: begin
                t_ticks[15:8] = b;
                word_crc      = crc8_step(word_crc, b);
            end
            3'd1: begin
                t_ticks[7:0] = b;
                word_crc     = crc8_step(word_crc, b);
            end
            3'd2: begin
                t_crc_good = (word_crc == b);
                word_crc   = hsfd_pkg::CRC_INIT;
            end
            3'd3: begin
                h_ticks[15:8] = b;
                word_crc      = crc8_step(word_crc, b);
            end
            3'd4: begin
                h_ticks[7:0] = b;
                word_crc     = crc8_step(word_crc, b);
            end
            default: begin
                h_good = (word_crc == b);
                t = (int'(hsfd_pkg::T_SCALE) * int'(t_ticks)) / int'(hsfd_pkg::TICKS_FULL)
                    - int'(hsfd_pkg::T_OFFSET);
                h = (int'(hsfd_pkg::H_SCALE) * int'(h_ticks)) / int'(hsfd_pkg::TICKS_FULL)
                    - int'(hsfd_pkg::H_OFFSET);
                if (h < 0) begin
                    h = 0;
                end else if (h > int'(hsfd_pkg::H_MAX)) begin
                    h = int'(hsfd_pkg::H_MAX);
                end
                r.temperature_c  = t_crc_good ? 9'(t) : '0;
                r.humidity_pct   = h_good ? 7'(h) : '0;
                r.temperature_ok = t_crc_good;
                r.humidity_ok    = h_good;
                expected_readings.push_back(r);
            end
        endcase
        frame_pos = (frame_pos >= 3'd5) ? 3'd0 : frame_pos + 3'd1;
        if (frame_pos == 3'd0) begin
            word_crc = hsfd_pkg::CRC_INIT;
        end
    endtask

    task automatic push_beat(input logic [7:0] b, input logic start, input bit drain);
        t_rx_beat beat;
        beat.data       = b;
        beat.start      = start;
        beat.wait_drain = drain;
        pending_beats.push_back(beat);
    endtask

    task automatic add_frame(input logic [15:0] t, input logic [15:0] h, input bit t_bad,
                             input bit h_bad, input logic start, input bit drain);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = word_crc8(t) ^ (t_bad ? 8'($urandom_range(1, 255)) : 8'h00);
        h_crc = word_crc8(h) ^ (h_bad ? 8'($urandom_range(1, 255)) : 8'h00);
        push_beat(t[15:8], start, drain);
        push_beat(t[7:0], 1'b0, 1'b0);
        push_beat(t_crc, 1'b0, 1'b0);
        push_beat(h[15:8], 1'b0, 1'b0);
        push_beat(h[7:0], 1'b0, 1'b0);
        push_beat(h_crc, 1'b0, 1'b0);
    endtask

    function automatic logic [15:0] pick_ticks();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 4000));
            3: return 16'($urandom_range(52000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    t_rx_beat current_beat;
    bit       presenting = 1'b0;
    int       gap_left = 0;

    function automatic int draw_gap(input int count, input int phase);
        if ((count / 48) % 4 == phase) begin
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid       <= 1'b0;
            rx_if.rx_byte     <= 8'h00;
            rx_if.frame_start <= 1'b0;
            presenting = 1'b0;
            gap_left   = draw_gap(beats_sent, 1);
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                decode_byte(current_beat.data, current_beat.start);
                beats_sent++;
                presenting = 1'b0;
                gap_left   = draw_gap(beats_sent, 1);
            end
            if (!presenting) begin
                if (gap_left > 0) begin
                    gap_left--;
                    rx_if.valid <= 1'b0;
                end else if (pending_beats.size() != 0 &&
                             !(pending_beats[0].wait_drain && expected_readings.size() != 0)) begin
                    current_beat = pending_beats.pop_front();
                    rx_if.valid       <= 1'b1;
                    rx_if.rx_byte     <= current_beat.data;
                    rx_if.frame_start <= current_beat.start;
                    presenting = 1'b1;
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    int stall_left = 0;

    always @(posedge i_clk) begin
        hsfd_pkg::t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = draw_gap(readings_seen, 2);
        end else begin
            if (res_if.valid && res_if.ready) begin
                readings_seen++;
                if (expected_readings.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Unexpected result transaction: t=%0d h=%0d t_ok=%b h_ok=%b",
                                 res_if.temperature_c, res_if.humidity_pct,
                                 res_if.temperature_ok, res_if.humidity_ok);
                    end
                end else begin
                    want = expected_readings.pop_front();
                    if (res_if.temperature_c !== want.temperature_c ||
                        res_if.humidity_pct !== want.humidity_pct ||
                        res_if.temperature_ok !== want.temperature_ok ||
                        res_if.humidity_ok !== want.humidity_ok) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("Mismatch on result %0d: expected t=%0d h=%0d ",
                                   readings_seen, want.temperature_c, want.humidity_pct);
                            $write("t_ok=%b h_ok=%b, ",
                                   want.temperature_ok, want.humidity_ok);
                            $display("got t=%0d h=%0d t_ok=%b h_ok=%b",
                                     res_if.temperature_c, res_if.humidity_pct,
                                     res_if.temperature_ok, res_if.humidity_ok);
                        end
                    end
                end
                stall_left = draw_gap(readings_seen, 2);
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int  kind;
        int  noise_len;
        bit  resync;
        int  next_drain;
        rx_if.valid       = 1'b0;
        rx_if.rx_byte     = 8'h00;
        rx_if.frame_start = 1'b0;
        res_if.ready      = 1'b0;

        frame_pos  = 3'd0;
        word_crc   = hsfd_pkg::CRC_INIT;
        t_ticks    = 16'h0000;
        h_ticks    = 16'h0000;
        t_crc_good = 1'b0;

        // Good temperature at zero ticks, humidity at full scale with a broken CRC.
        add_frame(16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0);
        // Back-to-back frame without a start flag: bad temperature CRC, humidity clamped low.
        add_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0);
        // A partial frame dropped by a start flag in mid-frame.
        push_beat(8'hFF, 1'b1, 1'b1);
        push_beat(8'h00, 1'b0, 1'b0);
        add_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0);
        add_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0);

        resync     = 1'b0;
        next_drain = 250;
        while (pending_beats.size() < 1125) begin
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                add_frame(pick_ticks(), pick_ticks(), $urandom_range(0, 9) == 0,
                          $urandom_range(0, 9) == 0,
                          resync ? 1'b1 : 1'($urandom_range(0, 1)),
                          pending_beats.size() >= next_drain);
                if (pending_beats.size() >= next_drain + 6) begin
                    next_drain += 250;
                end
                resync = 1'b0;
            end else begin
                noise_len = $urandom_range(1, 5);
                for (int i = 0; i < noise_len; i++) begin
                    push_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
                end
                resync = 1'b1;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || presenting) begin
            @(posedge i_clk);
        end
        while (expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
